// ===== hdl/tcp_flow_flag_counter_defines.svh =====
`ifndef TCP_FLOW_FLAG_COUNTER_DEFINES_SVH
`define TCP_FLOW_FLAG_COUNTER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define TFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/tfc_pkg.sv =====
`timescale 1ns / 1ps

package tfc_pkg;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam int          NUM_SLOTS      = 8;
  localparam logic [16:0] MIN_FRAME      = 17'd34;

  typedef logic [3:0] cfg_index_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] frame_len;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [3:0]  ip_ihl;
    logic [15:0] ip_len;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] tcp_sport;
    logic [15:0] tcp_dport;
    logic [3:0]  tcp_data_offset;
    logic [2:0]  tcp_flags;
  } in_t;

  typedef struct packed {
    logic        counted;
    logic [31:0] flow_ip;
    logic [15:0] flow_port;
    logic        new_entry;
    logic        evicted;
    logic [31:0] syn_total;
    logic [31:0] ack_total;
    logic [31:0] handshake_ack_total;
    logic [31:0] rst_total;
    logic [31:0] packet_total;
    logic [63:0] byte_total;
  } out_t;

  typedef struct packed {
    logic [31:0] syn;
    logic [31:0] ack;
    logic [31:0] hs_ack;
    logic [31:0] rst;
    logic [31:0] pkt;
    logic [63:0] bytes;
  } cnt_t;

  typedef struct packed {
    logic load;
    logic drop;
    logic scan_start;
    logic scan_step;
    logic select;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic pass;
    logic scan_done;
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_SELECT,
    ST_UPDATE
  } state_t;

endpackage

// ===== hdl/tcp_flow_flag_counter.sv =====
`timescale 1ns / 1ps

// Per-flow TCP counter. Pulse start with an item while busy is low; exactly
// one result follows on out_item, flagged by a one-cycle out_valid strobe that
// the receiver must take when it appears. A dropped item goes from start
// through the CHECK state to the strobe; a counted item goes through CHECK,
// a scan of the F table entries in use (at most TABLE_ENTRIES), SELECT and
// UPDATE, the key and timestamp memory being walked one entry per cycle. Port
// slots may be written only while busy is low and no result is pending.
module tcp_flow_flag_counter #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tfc_pkg::in_t        in_item,
  output logic                out_valid,
  output tfc_pkg::out_t       out_item,
  input  logic                cfg_we,
  input  tfc_pkg::cfg_index_t cfg_index,
  input  logic [15:0]         cfg_wdata
);

  tfc_pkg::cmd_t    cmd;
  tfc_pkg::status_t status;

  tfc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  tfc_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== hdl/tfc_ctrl.sv =====
`timescale 1ns / 1ps

module tfc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  tfc_pkg::status_t status,
  output tfc_pkg::cmd_t    cmd
);

  tfc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tfc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      tfc_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = tfc_pkg::ST_CHECK;
        end
      end
      tfc_pkg::ST_CHECK: begin
        if (status.pass) begin
          cmd.scan_start = 1'b1;
          state_nxt      = tfc_pkg::ST_SCAN;
        end else begin
          cmd.drop  = 1'b1;
          state_nxt = tfc_pkg::ST_IDLE;
        end
      end
      tfc_pkg::ST_SCAN: begin
        if (status.scan_done) begin
          state_nxt = tfc_pkg::ST_SELECT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      tfc_pkg::ST_SELECT: begin
        cmd.select = 1'b1;
        state_nxt  = tfc_pkg::ST_UPDATE;
      end
      tfc_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = tfc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tfc_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != tfc_pkg::ST_IDLE);

endmodule

// ===== hdl/tfc_datapath.sv =====
`timescale 1ns / 1ps
`include "tcp_flow_flag_counter_defines.svh"

module tfc_datapath #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tfc_pkg::in_t        in_item,
  input  logic                cfg_we,
  input  tfc_pkg::cfg_index_t cfg_index,
  input  logic [15:0]         cfg_wdata,
  input  tfc_pkg::cmd_t       cmd,
  output tfc_pkg::status_t    status,
  output logic                out_valid,
  output tfc_pkg::out_t       out_item
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam logic [IW:0] FULL = (IW + 1)'(TABLE_ENTRIES);
  localparam logic [IW:0] ONE  = (IW + 1)'(1);

  logic [15:0] slot_r [tfc_pkg::NUM_SLOTS];

  logic [47:0]         key_mem   [TABLE_ENTRIES];
  logic [63:0]         stamp_mem [TABLE_ENTRIES];
  tfc_pkg::cnt_t       cnt_mem   [TABLE_ENTRIES];

  tfc_pkg::in_t  in_r;
  logic [47:0]   key_r;
  logic [IW:0]   fill_r;
  logic [IW:0]   addr_r;
  logic [63:0]   stamp_r;
  logic [47:0]   key_rd_r;
  logic [63:0]   stamp_rd_r;
  logic [IW-1:0] cmp_idx_r;
  logic          cmp_vld_r;
  logic          hit_r;
  logic [IW-1:0] hit_idx_r;
  logic          lru_seen_r;
  logic [63:0]   lru_stamp_r;
  logic [IW-1:0] lru_idx_r;
  logic [IW-1:0] sel_idx_r;
  logic          new_r;
  logic          evict_r;
  tfc_pkg::cnt_t cnt_rd_r;
  tfc_pkg::out_t out_r;
  logic          out_valid_r;

  logic [15:0]   watched;
  logic [31:0]   peer;
  logic [15:0]   matched;
  logic          found;
  logic          len_ok;
  logic [IW-1:0] sel_idx;
  logic          full;
  logic [6:0]    hdrs;
  logic          syn, ack, rst, hs;
  tfc_pkg::cnt_t cnt_new;

  assign watched = in_r.mode ? in_r.tcp_sport : in_r.tcp_dport;
  assign peer    = in_r.mode ? in_r.dst_ip : in_r.src_ip;
  assign full    = (fill_r == FULL);

  always_comb begin
    matched = '0;
    found   = 1'b0;
    for (int i = tfc_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (slot_r[i] != '0 && slot_r[i] == watched) begin
        matched = slot_r[i];
        found   = 1'b1;
      end
    end
  end

  assign len_ok = ({1'b0, in_r.frame_len} >= tfc_pkg::MIN_FRAME) &&
                  ({1'b0, in_r.frame_len} >=
                   (tfc_pkg::MIN_FRAME + {11'd0, in_r.ip_ihl, 2'b00}));

  assign status.pass = len_ok && (in_r.ether_type == tfc_pkg::ETHERTYPE_IPV4) &&
                       (in_r.ip_protocol == tfc_pkg::PROTO_TCP) &&
                       (in_r.ip_ihl >= 4'd5) && found;
  assign status.scan_done = (addr_r == fill_r);

  assign hdrs = {1'b0, in_r.ip_ihl, 2'b00} + {1'b0, in_r.tcp_data_offset, 2'b00};
  assign syn  = in_r.tcp_flags[0];
  assign ack  = in_r.tcp_flags[1];
  assign rst  = in_r.tcp_flags[2];
  assign hs   = ack && !syn && !rst && (in_r.ip_len <= {9'd0, hdrs});

  always_comb begin
    if (hit_r) begin
      sel_idx = hit_idx_r;
    end else if (!full) begin
      sel_idx = fill_r[IW-1:0];
    end else begin
      sel_idx = lru_idx_r;
    end
  end

  always_comb begin
    if (new_r) begin
      cnt_new.syn    = {31'd0, syn};
      cnt_new.ack    = {31'd0, ack};
      cnt_new.hs_ack = {31'd0, hs};
      cnt_new.rst    = {31'd0, rst};
      cnt_new.pkt    = 32'd1;
      cnt_new.bytes  = {48'd0, in_r.frame_len};
    end else begin
      cnt_new.syn    = cnt_rd_r.syn + {31'd0, syn};
      cnt_new.ack    = cnt_rd_r.ack + {31'd0, ack};
      cnt_new.hs_ack = cnt_rd_r.hs_ack + {31'd0, hs};
      cnt_new.rst    = cnt_rd_r.rst + {31'd0, rst};
      cnt_new.pkt    = cnt_rd_r.pkt + 32'd1;
      cnt_new.bytes  = cnt_rd_r.bytes + {48'd0, in_r.frame_len};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tfc_pkg::NUM_SLOTS; i++) begin
        slot_r[i] <= '0;
      end
    end else if (cfg_we && (cfg_index < tfc_pkg::cfg_index_t'(tfc_pkg::NUM_SLOTS))) begin
      slot_r[cfg_index[2:0]] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      stamp_r     <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      out_valid_r <= cmd.drop || cmd.update;
      cmp_vld_r   <= cmd.scan_step;
      if (cmd.update) begin
        stamp_r <= stamp_r + 64'd1;
        if (new_r && !full) begin
          fill_r <= fill_r + ONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_item;
    end
    if (cmd.scan_start) begin
      key_r      <= {peer, matched};
      addr_r     <= '0;
      hit_r      <= 1'b0;
      lru_seen_r <= 1'b0;
    end
    if (cmd.scan_step) begin
      key_rd_r   <= key_mem[addr_r[IW-1:0]];
      stamp_rd_r <= stamp_mem[addr_r[IW-1:0]];
      cmp_idx_r  <= addr_r[IW-1:0];
      addr_r     <= addr_r + ONE;
    end
    if (cmp_vld_r) begin
      if (!hit_r && key_rd_r == key_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= cmp_idx_r;
      end
      if (!lru_seen_r || stamp_rd_r < lru_stamp_r) begin
        lru_seen_r  <= 1'b1;
        lru_stamp_r <= stamp_rd_r;
        lru_idx_r   <= cmp_idx_r;
      end
    end
    if (cmd.select) begin
      sel_idx_r <= sel_idx;
      new_r     <= !hit_r;
      evict_r   <= !hit_r && full;
      cnt_rd_r  <= cnt_mem[sel_idx];
    end
    if (cmd.update) begin
      cnt_mem[sel_idx_r]   <= cnt_new;
      key_mem[sel_idx_r]   <= key_r;
      stamp_mem[sel_idx_r] <= stamp_r;
      out_r.counted             <= 1'b1;
      out_r.flow_ip             <= key_r[47:16];
      out_r.flow_port           <= key_r[15:0];
      out_r.new_entry           <= new_r;
      out_r.evicted             <= evict_r;
      out_r.syn_total           <= cnt_new.syn;
      out_r.ack_total           <= cnt_new.ack;
      out_r.handshake_ack_total <= cnt_new.hs_ack;
      out_r.rst_total           <= cnt_new.rst;
      out_r.packet_total        <= cnt_new.pkt;
      out_r.byte_total          <= cnt_new.bytes;
    end else if (cmd.drop) begin
      out_r <= '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `TFC_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= FULL, "fill count beyond table size")
  `TFC_ASSERT_NOW(a_scan_bound, 1'b1, addr_r <= fill_r || !cmd.scan_step, "scan past filled entries")
  `TFC_ASSERT_NEXT(a_drop_zero, cmd.drop, out_valid && out_item == '0, "dropped item not zeroed")
  `TFC_ASSERT_NEXT(a_evict_full, cmd.update && evict_r, fill_r == FULL, "eviction with free entries")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int ENTRIES = 64;
  localparam int LINGER = ENTRIES + 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  tfc_pkg::in_t in_item = '0;
  logic out_valid;
  tfc_pkg::out_t out_item;
  logic cfg_we = 1'b0;
  tfc_pkg::cfg_index_t cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  tcp_flow_flag_counter #(.TABLE_ENTRIES(ENTRIES)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Flow table shadow
  logic [15:0]   watch_port [tfc_pkg::NUM_SLOTS];
  logic          flow_used [ENTRIES];
  logic [47:0]   flow_key [ENTRIES];
  tfc_pkg::cnt_t flow_cnt [ENTRIES];
  int            flow_age [ENTRIES];

  tfc_pkg::out_t expected_flows [$];
  int mismatches = 0;
  int unexpected = 0;
  int items_sent = 0;
  int counted_seen = 0;
  int evict_seen = 0;
  bit idle_on = 1'b1;
  logic [31:0] peer_pool [8];
  logic [15:0] port_pool [8];

  function automatic tfc_pkg::out_t predict_flow(tfc_pkg::in_t it);
    tfc_pkg::out_t r;
    logic [15:0] w, m;
    logic [31:0] peer;
    logic [47:0] key;
    int hdrs, payload, e, oldest, old_rank;
    bit hit, found;
    logic hs;
    r = '0;
    m = '0;
    found = 0;
    hit = 0;
    e = 0;
    oldest = 0;
    if (it.frame_len < 34 || it.ether_type != tfc_pkg::ETHERTYPE_IPV4 ||
        it.ip_protocol != tfc_pkg::PROTO_TCP || it.ip_ihl < 5 ||
        34 + 4 * int'(it.ip_ihl) > int'(it.frame_len))
      return r;
    w = it.mode ? it.tcp_sport : it.tcp_dport;
    peer = it.mode ? it.dst_ip : it.src_ip;
    for (int i = 0; i < tfc_pkg::NUM_SLOTS; i++)
      if (!found && watch_port[i] != 0 && watch_port[i] == w) begin
        m = watch_port[i];
        found = 1;
      end
    if (!found) return r;
    hdrs = 4 * int'(it.ip_ihl) + 4 * int'(it.tcp_data_offset);
    payload = (int'(it.ip_len) > hdrs) ? int'(it.ip_len) - hdrs : 0;
    hs = it.tcp_flags[1] && !it.tcp_flags[0] && !it.tcp_flags[2] && payload == 0;
    key = {peer, m};
    for (int i = 0; i < ENTRIES; i++)
      if (!hit && flow_used[i] && flow_key[i] == key) begin
        e = i;
        hit = 1;
      end
    if (hit) begin
      flow_cnt[e].pkt += 1;
      flow_cnt[e].bytes += 64'(it.frame_len);
      flow_cnt[e].syn += 32'(it.tcp_flags[0]);
      flow_cnt[e].ack += 32'(it.tcp_flags[1]);
      flow_cnt[e].hs_ack += 32'(hs);
      flow_cnt[e].rst += 32'(it.tcp_flags[2]);
    end else begin
      r.new_entry = 1'b1;
      found = 0;
      for (int i = 0; i < ENTRIES; i++)
        if (!found && !flow_used[i]) begin
          e = i;
          found = 1;
        end
      if (!found) begin
        r.evicted = 1'b1;
        for (int i = 0; i < ENTRIES; i++)
          if (flow_age[i] >= oldest) begin
            oldest = flow_age[i];
            e = i;
          end
      end
      flow_used[e] = 1'b1;
      flow_key[e] = key;
      flow_cnt[e] = '{syn: 32'(it.tcp_flags[0]), ack: 32'(it.tcp_flags[1]),
                      hs_ack: 32'(hs), rst: 32'(it.tcp_flags[2]), pkt: 32'd1,
                      bytes: 64'(it.frame_len)};
    end
    old_rank = flow_age[e];
    for (int i = 0; i < ENTRIES; i++)
      if (flow_age[i] < old_rank) flow_age[i]++;
    flow_age[e] = 0;
    r.counted = 1'b1;
    r.flow_ip = peer;
    r.flow_port = m;
    r.syn_total = flow_cnt[e].syn;
    r.ack_total = flow_cnt[e].ack;
    r.handshake_ack_total = flow_cnt[e].hs_ack;
    r.rst_total = flow_cnt[e].rst;
    r.packet_total = flow_cnt[e].pkt;
    r.byte_total = flow_cnt[e].bytes;
    return r;
  endfunction

  task automatic idle_burst();
    if (idle_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 7)) @(negedge clk);
  endtask

  task automatic send_packet(tfc_pkg::in_t it);
    idle_burst();
    while (busy) @(negedge clk);
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    expected_flows.push_back(predict_flow(it));
    items_sent++;
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic drain();
    while (expected_flows.size() != 0) @(negedge clk);
    repeat (LINGER) @(negedge clk);
  endtask

  task automatic set_port(int idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= tfc_pkg::cfg_index_t'(idx);
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx < tfc_pkg::NUM_SLOTS) watch_port[idx] = val;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_flows.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10) $display("unexpected result %p", out_item);
      end else begin
        tfc_pkg::out_t x;
        x = expected_flows.pop_front();
        if (out_item.counted) counted_seen++;
        if (out_item.evicted) evict_seen++;
        if (out_item !== x) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("mismatch: expected %p actual %p", x, out_item);
        end
      end
    end
  end

  function automatic tfc_pkg::in_t rand_item();
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(tfc_pkg::in_t)-1:0];
  endfunction

  function automatic tfc_pkg::in_t good_packet();
    tfc_pkg::in_t it;
    it = rand_item();
    it.ether_type = tfc_pkg::ETHERTYPE_IPV4;
    it.ip_protocol = tfc_pkg::PROTO_TCP;
    it.ip_ihl = 4'($urandom_range(5, 15));
    it.frame_len = 16'($urandom_range(34 + 4 * it.ip_ihl, 1600));
    if ($urandom_range(0, 9) == 0) it.frame_len = 16'($urandom_range(34 + 4 * it.ip_ihl, 65535));
    it.ip_len = $urandom_range(0, 1) ? 16'(4 * it.ip_ihl + 4 * it.tcp_data_offset)
                                     : 16'($urandom);
    it.src_ip = peer_pool[$urandom_range(0, 7)];
    it.dst_ip = peer_pool[$urandom_range(0, 7)];
    if ($urandom_range(0, 3) == 0) begin
      it.src_ip = $urandom;
      it.dst_ip = $urandom;
    end
    it.tcp_sport = port_pool[$urandom_range(0, 7)];
    it.tcp_dport = port_pool[$urandom_range(0, 7)];
    return it;
  endfunction

  task automatic test_directed();
    tfc_pkg::in_t it;
    set_port(0, 16'd80);
    set_port(1, 16'hFFFF);
    set_port(2, 16'd80);
    set_port(3, 16'd443);
    set_port(15, 16'd22);
    peer_pool = '{32'h0, 32'hFFFF_FFFF, 32'h0A00_0001, 32'hC0A8_0101,
                  32'h8000_0000, 32'h0000_0001, 32'h7F00_0001, 32'h5555_AAAA};
    port_pool = '{16'd80, 16'hFFFF, 16'd443, 16'd22, 16'd0, 16'd1, 16'd8080, 16'd443};
    it = '0;
    it.ether_type = tfc_pkg::ETHERTYPE_IPV4;
    it.ip_protocol = tfc_pkg::PROTO_TCP;
    it.ip_ihl = 4'd5;
    it.frame_len = 16'd54;
    it.tcp_dport = 16'd80;
    it.src_ip = 32'h0A00_0001;
    it.tcp_data_offset = 4'd5;
    it.ip_len = 16'd40;
    for (int f = 0; f < 8; f++) begin
      it.tcp_flags = 3'(f);
      send_packet(it);
    end
    it.tcp_flags = 3'd2;
    it.ip_len = 16'd41;
    send_packet(it);
    it.frame_len = 16'd13; send_packet(it);
    it.frame_len = 16'd33; send_packet(it);
    it.frame_len = 16'd53; send_packet(it);
    it.frame_len = 16'hFFFF; send_packet(it);
    it.ether_type = 16'h86DD; send_packet(it);
    it.ether_type = tfc_pkg::ETHERTYPE_IPV4;
    it.ip_protocol = 8'd17; send_packet(it);
    it.ip_protocol = tfc_pkg::PROTO_TCP;
    it.ip_ihl = 4'd4; send_packet(it);
    it.ip_ihl = 4'd15; it.frame_len = 16'd94; send_packet(it);
    it.ip_ihl = 4'd15; it.frame_len = 16'd93; send_packet(it);
    it.ip_ihl = 4'd5;
    it.mode = 1'b1; it.tcp_sport = 16'hFFFF; it.dst_ip = 32'hFFFF_FFFF; send_packet(it);
    it.tcp_sport = 16'd22; send_packet(it);
    it.tcp_sport = 16'd0; send_packet(it);
    it = '1; send_packet(it);
    drain();
  endtask

  task automatic test_random_mix();
    tfc_pkg::in_t it;
    for (int n = 0; n < 700; n++) begin
      if ($urandom_range(0, 4) == 0) it = rand_item();
      else it = good_packet();
      send_packet(it);
    end
    drain();
  endtask

  task automatic test_eviction();
    tfc_pkg::in_t it;
    set_port(4, 16'd1);
    set_port(5, 16'd0);
    set_port(6, 16'd8080);
    set_port(7, 16'd22);
    for (int n = 0; n < 500; n++) begin
      it = good_packet();
      if ($urandom_range(0, 1) == 0) begin
        it.mode = 1'b0;
        it.src_ip = 32'($urandom_range(0, 90));
        it.tcp_dport = 16'd1;
      end
      send_packet(it);
    end
    drain();
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    set_port(0, 16'd0);
    set_port(1, 16'hFFFF);
    for (int n = 0; n < 300; n++) send_packet(good_packet());
    drain();
  endtask

  initial begin
    for (int i = 0; i < tfc_pkg::NUM_SLOTS; i++) watch_port[i] = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      flow_used[i] = 1'b0;
      flow_key[i] = '0;
      flow_cnt[i] = '0;
      flow_age[i] = i;
    end
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random_mix();
    test_eviction();
    test_no_idle();
    $display("sent %0d items: %0d counted, %0d evictions, %0d errors",
             items_sent, counted_seen, evict_seen, mismatches + unexpected);
    if (mismatches == 0 && unexpected == 0 && expected_flows.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tfc_pkg.sv
hdl/tfc_ctrl.sv
hdl/tfc_datapath.sv
hdl/tcp_flow_flag_counter.sv
verif/tb_top.sv
